### rtl/mrx_pkg.sv
// Shared types, constants and the CRC-16 step function for the Modbus RTU frame receiver.
package mrx_pkg;

    localparam int MRX_BUFFER_BYTES = 64;
    localparam int FRAME_OVERHEAD   = 3;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIVER_EN = 1'b1;

    typedef enum logic [2:0] {
        ST_PAYLOAD    = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_BAD_CRC    = 3'd2,
        ST_OTHER_ADDR = 3'd3,
        ST_DISABLED   = 3'd4,
        ST_OVERFLOW   = 3'd5
    } t_status;

    typedef enum logic {
        K_BYTE    = 1'b0,
        K_SILENCE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_FETCH = 2'd1,
        S_EMIT  = 2'd2
    } t_bstate;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] payload_byte;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] rx_byte;
    } t_queue_head;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/modbus_rtu_frame_receiver_core.sv
// Top level of the Modbus RTU frame receiver: configuration registers, front end and back end.
//
// Usage: a command (i_in.cmd 0 = received character in i_in.rx_byte, 1 = end of the
// inter-frame silence) is transferred at a rising edge where i_start is high and o_busy
// is low. A two-entry queue sits in front of the frame engine, so o_busy only rises when
// that queue is full. Configuration is written through i_cfg_we, i_cfg_index and
// i_cfg_data with no wait: index 0 is the slave address, index 1 the deliver enable.
// Each result is shown on o_out for exactly one cycle with o_strobe high; the receiver
// cannot stall it, so it must take every strobed transfer.
// A character passes through the queue and is absorbed by the engine while it is idle,
// and the queue drains as fast as it fills while the engine is idle, so characters may
// then follow one another every cycle. At silence a frame that is not delivered gives a
// single status result, registered in the output register; a good frame is emitted as
// N consecutive payload bytes, read from the frame buffer in the FETCH and EMIT states
// and then registered at the output, and the engine takes no command while in FETCH and
// EMIT. Commands arriving meanwhile wait in the queue.
// Reset clears the queue and the frame state, presets the running CRCs to FFFF, and loads slave
// address 1 with delivery disabled; the frame buffer needs no clearing.
module modbus_rtu_frame_receiver_core
    import mrx_pkg::*;
#(
    parameter int BUFFER_BYTES = MRX_BUFFER_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_in_item              i_in,
    output logic                  o_busy,
    output logic                  o_strobe,
    output t_out_item             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [7:0]  r_slave_address;
    logic        r_deliver_enable;
    t_queue_head head;
    logic        pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address  <= 8'd1;
            r_deliver_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SLAVE_ADDR: r_slave_address  <= i_cfg_data[7:0];
                REG_DELIVER_EN: r_deliver_enable <= i_cfg_data[0];
                default: r_deliver_enable <= r_deliver_enable;
            endcase
        end
    end

    mrx_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_head  (head),
        .i_pop   (pop)
    );

    mrx_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .o_pop            (pop),
        .i_slave_address  (r_slave_address),
        .i_deliver_enable (r_deliver_enable),
        .o_strobe         (o_strobe),
        .o_out            (o_out)
    );

endmodule

### rtl/mrx_front.sv
// Front end: takes commands, classifies them and holds them in a two-entry queue.
module mrx_front
    import mrx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_in_item    i_in,
    output logic        o_busy,
    output t_queue_head o_head,
    input  logic        i_pop
);

    typedef struct packed {
        t_kind      kind;
        logic [7:0] rx_byte;
    } t_entry;

    t_entry     r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_fill, n_fill;
    logic       push;
    logic       pop;

    assign o_busy = (r_fill == 2'd2);
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_fill != 2'd0);

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr].kind    <= i_in.cmd ? K_SILENCE : K_BYTE;
            r_q[r_wr_ptr].rx_byte <= i_in.rx_byte;
        end
    end

    always_comb begin
        o_head.valid   = (r_fill != 2'd0);
        o_head.kind    = r_q[r_rd_ptr].kind;
        o_head.rx_byte = r_q[r_rd_ptr].rx_byte;
    end

endmodule

### rtl/mrx_back.sv
// Back end: frame buffer, running CRCs, frame checking and result emission.
module mrx_back
    import mrx_pkg::*;
#(
    parameter int BUFFER_BYTES = MRX_BUFFER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    output logic        o_pop,
    input  logic [7:0]  i_slave_address,
    input  logic        i_deliver_enable,
    output logic        o_strobe,
    output t_out_item   o_out
);

    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int IW = $clog2(BUFFER_BYTES);

    logic [7:0]    mem [BUFFER_BYTES];

    t_bstate       r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [15:0]   r_crc0, n_crc0;
    logic [15:0]   r_crc1, n_crc1;
    logic [7:0]    r_byte0, n_byte0;
    logic [7:0]    r_byte1, n_byte1;
    logic [IW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_left, n_left;
    logic [7:0]    r_rd_data;
    t_out_item     r_out, n_out;
    logic          r_strobe, n_strobe;

    logic          is_byte;
    logic          is_silence;
    logic          has_room;
    logic          mem_we;
    logic          good0;
    logic          good1;
    logic          start;
    logic [7:0]    addr_byte;
    logic [CW-1:0] len;
    logic          deliver;

    assign is_byte    = (r_state == S_IDLE) && i_head.valid && (i_head.kind == K_BYTE);
    assign is_silence = (r_state == S_IDLE) && i_head.valid && (i_head.kind == K_SILENCE);
    assign has_room   = (r_count < CW'(BUFFER_BYTES));
    assign mem_we     = is_byte && has_room;

    assign good0     = (r_count >= CW'(FRAME_OVERHEAD)) && (r_crc0 == 16'h0000);
    assign good1     = (r_count >= CW'(FRAME_OVERHEAD + 1)) && (r_crc1 == 16'h0000);
    assign start     = !good0;
    assign addr_byte = good0 ? r_byte0 : r_byte1;
    assign len       = r_count - {{(CW-1){1'b0}}, start} - CW'(FRAME_OVERHEAD);
    assign deliver   = i_deliver_enable && !r_ovf && (good0 || good1)
                       && (addr_byte == i_slave_address) && (len != '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (is_silence && deliver) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (r_left == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop    = (r_state == S_IDLE) && i_head.valid;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_crc0   = r_crc0;
        n_crc1   = r_crc1;
        n_byte0  = r_byte0;
        n_byte1  = r_byte1;
        n_ptr    = r_ptr;
        n_left   = r_left;
        n_out    = r_out;
        n_strobe = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (is_byte) begin
                    if (has_room) begin
                        n_crc0  = crc_feed(r_crc0, i_head.rx_byte);
                        if (r_count != '0) begin
                            n_crc1 = crc_feed(r_crc1, i_head.rx_byte);
                        end
                        if (r_count == CW'(0)) begin
                            n_byte0 = i_head.rx_byte;
                        end
                        if (r_count == CW'(1)) begin
                            n_byte1 = i_head.rx_byte;
                        end
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else if (is_silence) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_crc0  = 16'hFFFF;
                    n_crc1  = 16'hFFFF;
                    n_ptr   = {{(IW-1){1'b0}}, start} + IW'(1);
                    n_left  = len;
                    n_out.payload_byte = 8'h00;
                    n_out.last         = 1'b1;
                    if (!i_deliver_enable) begin
                        n_out.status = ST_DISABLED;
                        n_strobe     = 1'b1;
                    end else if (r_ovf) begin
                        n_out.status = ST_OVERFLOW;
                        n_strobe     = 1'b1;
                    end else if (!good0 && !good1) begin
                        n_out.status = ST_BAD_CRC;
                        n_strobe     = 1'b1;
                    end else if (addr_byte != i_slave_address) begin
                        n_out.status = ST_OTHER_ADDR;
                        n_strobe     = 1'b1;
                    end else if (len == '0) begin
                        n_out.status = ST_EMPTY;
                        n_strobe     = 1'b1;
                    end
                end
            end
            S_FETCH: begin
                n_ptr = r_ptr + IW'(1);
            end
            S_EMIT: begin
                n_ptr              = r_ptr + IW'(1);
                n_left             = r_left - CW'(1);
                n_out.status       = ST_PAYLOAD;
                n_out.payload_byte = r_rd_data;
                n_out.last         = (r_left == CW'(1));
                n_strobe           = 1'b1;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_crc0   <= 16'hFFFF;
            r_crc1   <= 16'hFFFF;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_crc0   <= n_crc0;
            r_crc1   <= n_crc1;
            r_left   <= n_left;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte0 <= n_byte0;
        r_byte1 <= n_byte1;
        r_ptr   <= n_ptr;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[IW-1:0]] <= i_head.rx_byte;
        end
        r_rd_data <= mem[r_ptr];
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule
